// ===== hw/rtl/esc_pkg.sv =====
// Shared types and codes for the expression syntax checker.
package esc_pkg;

  // Token kinds on the input channel.
  localparam logic [2:0] KIND_VALUE  = 3'd0;
  localparam logic [2:0] KIND_OP     = 3'd1;
  localparam logic [2:0] KIND_LPAREN = 3'd2;
  localparam logic [2:0] KIND_RPAREN = 3'd3;
  localparam logic [2:0] KIND_FUNC   = 3'd4;

  // Result status codes.
  localparam logic [3:0] ST_OK             = 4'd0;
  localparam logic [3:0] ST_OP_EXPECTED    = 4'd1;
  localparam logic [3:0] ST_PAREN_EXPECTED = 4'd2;
  localparam logic [3:0] ST_BAD_OP         = 4'd3;
  localparam logic [3:0] ST_BAD_PAREN      = 4'd4;
  localparam logic [3:0] ST_VALUE_EXPECTED = 4'd5;
  localparam logic [3:0] ST_MISMATCH       = 4'd6;
  localparam logic [3:0] ST_UNENDED        = 4'd7;
  localparam logic [3:0] ST_OVERFLOW       = 4'd8;
  localparam logic [3:0] ST_SKIPPED        = 4'd9;

  // Symbols of the bracket stack. A value only ever sits on top, so it is
  // kept as a flag; a function directly followed by '(' is merged into one
  // symbol so that a closing parenthesis pops exactly one symbol.
  typedef logic [1:0] sym_t;
  localparam sym_t SYM_L  = 2'd0;
  localparam sym_t SYM_F  = 2'd1;
  localparam sym_t SYM_FL = 2'd2;

  // Stack state as seen by the token decoder.
  typedef struct packed {
    logic err;
    logic vflag;
    logic sym_empty;
    logic sym_one;
    logic full;
    sym_t top;
  } stk_view_t;

  // Stack update requested by the token decoder.
  typedef struct packed {
    logic push;
    logic pop;
    logic replace;
    sym_t sym;
    logic vflag_set;
    logic vflag_clr;
    logic cnt_inc;
    logic cnt_dec1;
    logic cnt_dec2;
    logic set_err;
  } stk_act_t;

endpackage

// ===== hw/rtl/esc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module esc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/esc_step.sv =====
// Token decoder: status, error position and stack update for one token.
module esc_step import esc_pkg::*; #(
  parameter int POS_W = 16
) (
  input  logic [2:0]       token_kind,
  input  logic [POS_W-1:0] position,
  input  logic             last,
  input  stk_view_t        view,
  output logic [3:0]       status,
  output logic [POS_W-1:0] error_position,
  output stk_act_t         act
);

  logic             top_f;
  logic [POS_W-1:0] end_pos;
  logic [3:0]       op_st;
  stk_act_t         op_act;
  logic             vflag_after;
  logic             empty_after;

  assign top_f   = !view.sym_empty && (view.top == SYM_F);
  assign end_pos = (position == '1) ? position : position + POS_W'(1);

  always_comb begin
    op_act = '0;
    op_st  = ST_OK;
    case (token_kind)
      KIND_VALUE: begin
        if (view.vflag) op_st = ST_OP_EXPECTED;
        else if (top_f) op_st = ST_PAREN_EXPECTED;
        else if (view.full) op_st = ST_OVERFLOW;
        else begin
          op_act.vflag_set = 1'b1;
          op_act.cnt_inc   = 1'b1;
        end
      end
      KIND_OP: begin
        if (!view.vflag) op_st = ST_BAD_OP;
        else begin
          op_act.vflag_clr = 1'b1;
          op_act.cnt_dec1  = 1'b1;
        end
      end
      KIND_LPAREN: begin
        if (view.vflag) op_st = ST_BAD_PAREN;
        else if (view.full) op_st = ST_OVERFLOW;
        else begin
          op_act.cnt_inc = 1'b1;
          if (top_f) begin
            op_act.replace = 1'b1;
            op_act.sym     = SYM_FL;
          end else begin
            op_act.push = 1'b1;
            op_act.sym  = SYM_L;
          end
        end
      end
      KIND_RPAREN: begin
        if (!view.vflag) op_st = top_f ? ST_BAD_PAREN : ST_VALUE_EXPECTED;
        else if (view.sym_empty || top_f) op_st = ST_MISMATCH;
        else begin
          // The value stays on top; '(' and any function below fold into it.
          op_act.pop = 1'b1;
          if (view.top == SYM_FL) op_act.cnt_dec2 = 1'b1;
          else op_act.cnt_dec1 = 1'b1;
        end
      end
      KIND_FUNC: begin
        if (view.vflag) op_st = ST_OP_EXPECTED;
        else if (view.full) op_st = ST_OVERFLOW;
        else begin
          op_act.push    = 1'b1;
          op_act.sym     = SYM_F;
          op_act.cnt_inc = 1'b1;
        end
      end
      default: begin
        op_st = ST_OK;
      end
    endcase
  end

  assign vflag_after = (view.vflag | op_act.vflag_set) & ~op_act.vflag_clr;
  assign empty_after = (op_act.push || op_act.replace) ? 1'b0 :
                       op_act.pop ? view.sym_one : view.sym_empty;

  always_comb begin
    status         = op_st;
    error_position = '0;
    act            = op_act;
    if (view.err) begin
      status = ST_SKIPPED;
      act    = '0;
    end else if (op_st != ST_OK) begin
      error_position = position;
      act            = '0;
      act.set_err    = 1'b1;
    end else if (last) begin
      if (empty_after && !vflag_after) begin
        status         = ST_VALUE_EXPECTED;
        error_position = end_pos;
      end else if (!(empty_after && vflag_after)) begin
        status         = ST_UNENDED;
        error_position = end_pos;
      end
    end
  end

endmodule

// ===== hw/rtl/expression_syntax_checker.sv =====
// Top level of the infix expression syntax checker.
//
//   Channel  Ports                                              Transfer when
//   in       in_token_kind, in_position, in_last                in_valid & in_ready
//   out      out_status, out_error_position, out_expression_done out_valid & out_ready
//
// One token is taken per cycle while the result side is not stalled. A token
// waits in the input register until it is decided, and its result is then
// held in the result register on the output ports until the receiver takes it.
// The token-to-token loop closes through the top-of-stack register and a
// one-entry bypass in front of the stack RAM read port.
// Reset is synchronous and active low; it empties the stack at once, and the
// stack RAM itself needs no clearing pass because entries are only read after
// they are written. A stalled result holds only the token behind it; the
// input side stays ready while the input register is empty or moving.
module expression_syntax_checker import esc_pkg::*; #(
  parameter int STACK_DEPTH   = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_token_kind,
  input  logic [POSITION_BITS-1:0] in_position,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               out_status,
  output logic [POSITION_BITS-1:0] out_error_position,
  output logic                     out_expression_done
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int NW = $clog2(STACK_DEPTH + 1);

  // Input register.
  logic                     in_valid_r, in_valid_nxt;
  logic [2:0]               in_kind_r;
  logic [POSITION_BITS-1:0] in_pos_r;
  logic                     in_last_r;

  // Result register.
  logic                     out_valid_r, out_valid_nxt;
  logic [3:0]               out_status_r;
  logic [POSITION_BITS-1:0] out_epos_r;
  logic                     out_done_r;

  // Stack state. The symbol below the top lives in the RAM at nsym_r - 2;
  // after a push it is served from fwd_r until the RAM read catches up.
  logic [NW-1:0] nsym_r, nsym_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  sym_t          top_r, top_nxt;
  logic          vflag_r, vflag_nxt;
  logic          err_r, err_nxt;
  logic          fwd_valid_r, fwd_valid_nxt;
  sym_t          fwd_r, fwd_nxt;

  logic          advance;
  logic          in_xfer;
  sym_t          below;
  sym_t          ram_rdata;
  logic          ram_we;
  logic [NW-1:0] nsym_m1;
  logic [NW-1:0] nsym_nxt_m2;

  stk_view_t                view;
  stk_act_t                 act;
  logic [3:0]               step_status;
  logic [POSITION_BITS-1:0] step_epos;

  // A token in the input register is decided when the result register can
  // take its result.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  assign below = fwd_valid_r ? fwd_r : ram_rdata;

  assign view.err       = err_r;
  assign view.vflag     = vflag_r;
  assign view.sym_empty = (nsym_r == '0);
  assign view.sym_one   = (nsym_r == NW'(1));
  assign view.full      = (cnt_r == NW'(STACK_DEPTH));
  assign view.top       = top_r;

  esc_step #(
    .POS_W (POSITION_BITS)
  ) u_step (
    .token_kind     (in_kind_r),
    .position       (in_pos_r),
    .last           (in_last_r),
    .view           (view),
    .status         (step_status),
    .error_position (step_epos),
    .act            (act)
  );

  always_comb begin
    nsym_nxt      = nsym_r;
    cnt_nxt       = cnt_r;
    top_nxt       = top_r;
    vflag_nxt     = vflag_r;
    err_nxt       = err_r;
    fwd_valid_nxt = fwd_valid_r;
    fwd_nxt       = fwd_r;
    ram_we        = 1'b0;
    if (advance) begin
      if (in_last_r) begin
        // The end of an expression clears everything, whatever its status.
        nsym_nxt      = '0;
        cnt_nxt       = '0;
        vflag_nxt     = 1'b0;
        err_nxt       = 1'b0;
        fwd_valid_nxt = 1'b0;
      end else begin
        err_nxt   = err_r | act.set_err;
        vflag_nxt = (vflag_r | act.vflag_set) & ~act.vflag_clr;
        if (act.cnt_inc) cnt_nxt = cnt_r + NW'(1);
        else if (act.cnt_dec2) cnt_nxt = cnt_r - NW'(2);
        else if (act.cnt_dec1) cnt_nxt = cnt_r - NW'(1);
        if (act.push) begin
          // The old top moves down into the RAM.
          ram_we        = (nsym_r != '0);
          top_nxt       = act.sym;
          nsym_nxt      = nsym_r + NW'(1);
          fwd_valid_nxt = (nsym_r != '0);
          fwd_nxt       = top_r;
        end else if (act.pop) begin
          top_nxt       = below;
          nsym_nxt      = nsym_r - NW'(1);
          fwd_valid_nxt = 1'b0;
        end else if (act.replace) begin
          top_nxt = act.sym;
        end
      end
    end
  end

  assign nsym_m1     = nsym_r - NW'(1);
  assign nsym_nxt_m2 = nsym_nxt - NW'(2);

  esc_ram #(
    .WIDTH ($bits(sym_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (nsym_m1[AW-1:0]),
    .wdata (top_r),
    .raddr (nsym_nxt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      nsym_r      <= '0;
      cnt_r       <= '0;
      top_r       <= SYM_L;
      vflag_r     <= 1'b0;
      err_r       <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      nsym_r      <= nsym_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      vflag_r     <= vflag_nxt;
      err_r       <= err_nxt;
      fwd_valid_r <= fwd_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    fwd_r <= fwd_nxt;
    if (in_xfer) begin
      in_kind_r <= in_token_kind;
      in_pos_r  <= in_position;
      in_last_r <= in_last;
    end
    if (advance) begin
      out_status_r <= step_status;
      out_epos_r   <= step_epos;
      out_done_r   <= in_last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_error_position  = out_epos_r;
  assign out_expression_done = out_done_r;

endmodule

// ===== hw/rtl/esc_checker.sv =====
// Port-level assertions for the expression syntax checker, bound to the top level.
module esc_checker import esc_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [3:0]               out_status,
  input logic [POSITION_BITS-1:0] out_error_position,
  input logic                     out_expression_done
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_error_position) && $stable(out_expression_done))
    else $error("result changed while stalled");

  // No result is presented right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Clean and skipped tokens carry no error position.
  a_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_SKIPPED)
      |-> out_error_position == '0)
    else $error("error position on a clean result");

  // An unended expression can only be reported on its final token.
  a_unended_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNENDED |-> out_expression_done)
    else $error("unended reported before the final token");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_SKIPPED)
    else $error("undefined status code");

endmodule

bind expression_syntax_checker esc_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_esc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_error_position  (out_error_position),
  .out_expression_done (out_expression_done)
);

// ===== tb/sv/expression_syntax_checker_tb.sv =====
// Self-checking testbench for the expression syntax checker: token stream, predictor, checks.
module expression_syntax_checker_tb;
  import esc_pkg::*;

  localparam int STACK_DEPTH   = 64;
  localparam int POSITION_BITS = 16;
  // Counted tokens in the random part; ignored token kinds do not count.
  localparam int RANDOM_TOKENS = 1000;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  // Quiet cycles after the last result, to catch anything extra from the block.
  localparam int DRAIN_CYCLES  = 8;

  // What the predictor keeps on its nesting stack.
  typedef enum logic [1:0] {NEST_VALUE, NEST_LPAREN, NEST_FUNC, NEST_NONE} nest_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic [POSITION_BITS-1:0] pos;
    logic                     last;
  } token_t;

  typedef struct packed {
    logic [3:0]               status;
    logic [POSITION_BITS-1:0] err_pos;
    logic                     done;
  } verdict_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               in_token_kind = '0;
  logic [POSITION_BITS-1:0] in_position = '0;
  logic                     in_last = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [3:0]               out_status;
  logic [POSITION_BITS-1:0] out_error_position;
  logic                     out_expression_done;

  expression_syntax_checker #(
    .STACK_DEPTH  (STACK_DEPTH),
    .POSITION_BITS(POSITION_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_token_kind      (in_token_kind),
    .in_position        (in_position),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_error_position (out_error_position),
    .out_expression_done(out_expression_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Token stream waiting to be driven, and the verdicts still owed by the block.
  token_t   pending_tokens[$];
  verdict_t verdict_q[$];

  // Predictor state: a private copy of the nesting stack and the error flag.
  nest_t    nest_kinds[STACK_DEPTH];
  int       nest_depth = 0;
  bit       expr_failed = 1'b0;

  // Stimulus bookkeeping.
  logic [2:0]               expr_kinds[$];
  logic [POSITION_BITS-1:0] next_pos = '0;
  int                       counted_tokens = 0;
  int                       tokens_sent = 0;
  int                       phase_len = 0;
  token_t                   next_tok;
  bit                       tok_taken = 1'b0;

  int mismatch_count = 0;
  int stall_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Kind of the entry 'below' places under the top, or NEST_NONE past the bottom.
  function automatic nest_t nest_peek(int below);
    if (nest_depth <= below) return NEST_NONE;
    return nest_kinds[nest_depth - 1 - below];
  endfunction

  function automatic logic [3:0] nest_push(nest_t k);
    if (nest_depth >= STACK_DEPTH) return ST_OVERFLOW;
    nest_kinds[nest_depth] = k;
    nest_depth++;
    return ST_OK;
  endfunction

  // Applies one token to the stack and returns its status.
  function automatic logic [3:0] apply_kind(logic [2:0] kind);
    nest_t top;
    top = nest_peek(0);
    case (kind)
      KIND_VALUE: begin
        if (top == NEST_VALUE) return ST_OP_EXPECTED;
        if (top == NEST_FUNC) return ST_PAREN_EXPECTED;
        return nest_push(NEST_VALUE);
      end
      KIND_OP: begin
        // An operator consumes the value on top; the next operand replaces it.
        if (top != NEST_VALUE) return ST_BAD_OP;
        nest_depth--;
        return ST_OK;
      end
      KIND_LPAREN: begin
        if (top == NEST_VALUE) return ST_BAD_PAREN;
        return nest_push(NEST_LPAREN);
      end
      KIND_RPAREN: begin
        if (top == NEST_NONE || top == NEST_LPAREN) return ST_VALUE_EXPECTED;
        if (top != NEST_VALUE) return ST_BAD_PAREN;
        if (nest_peek(1) != NEST_LPAREN) return ST_MISMATCH;
        // Fold value and '(' (and a function call in front of it) into one value.
        nest_depth -= 2;
        if (nest_peek(0) == NEST_FUNC) nest_depth--;
        return nest_push(NEST_VALUE);
      end
      KIND_FUNC: begin
        if (top == NEST_VALUE) return ST_OP_EXPECTED;
        return nest_push(NEST_FUNC);
      end
      default: return ST_OK;
    endcase
  endfunction

  function automatic verdict_t predict_verdict(token_t t);
    verdict_t                 v;
    logic [POSITION_BITS-1:0] end_pos;
    v.status  = ST_OK;
    v.err_pos = '0;
    v.done    = t.last;
    if (expr_failed) begin
      v.status = ST_SKIPPED;
    end else begin
      v.status = apply_kind(t.kind);
      if (v.status != ST_OK) begin
        expr_failed = 1'b1;
        v.err_pos   = t.pos;
      end else if (t.last) begin
        // The end check reports one past the last token, saturating.
        end_pos = (t.pos == '1) ? t.pos : t.pos + 1'b1;
        if (nest_depth == 0) begin
          v.status  = ST_VALUE_EXPECTED;
          v.err_pos = end_pos;
        end else if (nest_depth != 1 || nest_peek(0) != NEST_VALUE) begin
          v.status  = ST_UNENDED;
          v.err_pos = end_pos;
        end
      end
    end
    if (t.last) begin
      nest_depth  = 0;
      expr_failed = 1'b0;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_token(logic [2:0] kind, logic [POSITION_BITS-1:0] pos, logic last);
    token_t t;
    t.kind = kind;
    t.pos  = pos;
    t.last = last;
    pending_tokens.push_back(t);
    if (kind <= KIND_FUNC) counted_tokens++;
  endtask

  // Builds a well-formed expression with the given number of operands. Parentheses
  // and function calls nest up to max_nest deep; ignored kinds are sprinkled in.
  task automatic build_well_formed(int operands, int max_nest);
    int depth;
    int left;
    int r;
    bit want_operand;
    expr_kinds.delete();
    depth = 0;
    left = operands;
    want_operand = 1'b1;
    while (left > 0 || depth > 0 || want_operand) begin
      if (want_operand) begin
        r = $urandom_range(0, 9);
        if (depth < max_nest && r < 2) begin
          expr_kinds.push_back(KIND_LPAREN);
          depth++;
        end else if (depth < max_nest && r < 4) begin
          expr_kinds.push_back(KIND_FUNC);
          expr_kinds.push_back(KIND_LPAREN);
          depth++;
        end else begin
          expr_kinds.push_back(KIND_VALUE);
          left--;
          want_operand = 1'b0;
        end
      end else if (depth > 0 && (left <= 0 || $urandom_range(0, 2) == 0)) begin
        expr_kinds.push_back(KIND_RPAREN);
        depth--;
      end else if (left > 0) begin
        expr_kinds.push_back(KIND_OP);
        want_operand = 1'b1;
      end
      if ($urandom_range(0, 29) == 0) expr_kinds.push_back(3'($urandom_range(5, 7)));
    end
  endtask

  // Nests until the stack holds 'target' entries, then one value. Below the
  // stack depth the expression is closed properly; at or above it, a push
  // overflows and the rest of the expression is skipped anyway.
  task automatic build_deep(int target);
    int entries;
    int groups;
    expr_kinds.delete();
    entries = 0;
    groups = 0;
    while (entries < target) begin
      if (target - entries >= 2 && $urandom_range(0, 1) == 1) begin
        expr_kinds.push_back(KIND_FUNC);
        expr_kinds.push_back(KIND_LPAREN);
        entries += 2;
      end else begin
        expr_kinds.push_back(KIND_LPAREN);
        entries++;
      end
      groups++;
    end
    expr_kinds.push_back(KIND_VALUE);
    if (target < STACK_DEPTH) repeat (groups) expr_kinds.push_back(KIND_RPAREN);
  endtask

  // Breaks a well-formed expression in one of several ways.
  task automatic mutate_expr();
    int idx;
    case ($urandom_range(0, 3))
      0: begin
        idx = $urandom_range(0, expr_kinds.size() - 1);
        expr_kinds[idx] = 3'($urandom_range(0, 7));
      end
      1: begin
        idx = $urandom_range(1, expr_kinds.size());
        while (expr_kinds.size() > idx) void'(expr_kinds.pop_back());
      end
      2: begin
        idx = $urandom_range(0, expr_kinds.size());
        expr_kinds.insert(idx, 3'($urandom_range(0, 4)));
      end
      default: begin
        expr_kinds.delete();
        repeat ($urandom_range(1, 6)) expr_kinds.push_back(3'($urandom_range(0, 7)));
      end
    endcase
  endtask

  // Queues the built expression with rising positions; the final token is
  // marked last and now and then sits at the top position to test saturation.
  task automatic emit_expr();
    logic [POSITION_BITS-1:0] pos;
    logic                     last;
    if ($urandom_range(0, 3) == 0) next_pos = POSITION_BITS'($urandom_range(0, 65535));
    foreach (expr_kinds[i]) begin
      last = (i == expr_kinds.size() - 1);
      pos = next_pos;
      if (last && $urandom_range(0, 7) == 0) pos = '1;
      add_token(expr_kinds[i], pos, last);
      next_pos = next_pos + POSITION_BITS'($urandom_range(1, 8));
    end
  endtask

  // Idle rates: the sender idles lightly while the receiver stalls a lot, then
  // the other way round, and the last third of the stream runs with no idling.
  function automatic int send_idle_pct();
    if (tokens_sent < phase_len) return 13;
    if (tokens_sent < 2 * phase_len) return 47;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (tokens_sent < phase_len) return 47;
    if (tokens_sent < 2 * phase_len) return 13;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A new token is presented only
  // when the line is empty or the previous token was transferred at the last
  // rising edge, so valid never drops while a token is still waiting.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || tok_taken) begin
        if (pending_tokens.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          next_tok = pending_tokens.pop_front();
          in_valid      <= 1'b1;
          in_token_kind <= next_tok.kind;
          in_position   <= next_tok.pos;
          in_last       <= next_tok.last;
          tokens_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. Each input transfer is
  // run through the predictor; each result transfer is checked against the
  // oldest verdict still owed. The watchdog ends a run that stops moving.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    token_t   seen;
    tok_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen.kind = in_token_kind;
        seen.pos  = in_position;
        seen.last = in_last;
        verdict_q.push_back(predict_verdict(seen));
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none expected: status %0d, position %0d, done %0d",
                   $time, out_status, out_error_position, out_expression_done);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            mismatch_count++;
          end
          if (out_error_position !== want.err_pos) begin
            $display("%0t: error position expected %0d, got %0d",
                     $time, want.err_pos, out_error_position);
            mismatch_count++;
          end
          if (out_expression_done !== want.done) begin
            $display("%0t: expression done expected %0d, got %0d",
                     $time, want.done, out_expression_done);
            mismatch_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stream setup, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int expr_index;

    // Directed part. A single value at the lowest position is a complete expression.
    add_token(KIND_VALUE, '0, 1'b1);
    // An operator with nothing before it is an error on the last token, so the
    // end check is not made.
    add_token(KIND_OP, 16'h1234, 1'b1);
    // A lone '(' at the top position leaves the stack unended; the end position
    // saturates instead of wrapping.
    add_token(KIND_LPAREN, '1, 1'b1);
    // A function one below the top position: end position lands on the top.
    add_token(KIND_FUNC, 16'hFFFE, 1'b1);
    // Ignored kinds only: the stack stays empty, so a value is expected at the end.
    add_token(3'd5, 16'h0004, 1'b0);
    add_token(3'd7, 16'h0005, 1'b1);
    // f ( a ) + b with an ignored kind in the middle.
    add_token(KIND_FUNC, 16'h0010, 1'b0);
    add_token(KIND_LPAREN, 16'h0011, 1'b0);
    add_token(3'd6, 16'h0012, 1'b0);
    add_token(KIND_VALUE, 16'h0013, 1'b0);
    add_token(KIND_RPAREN, 16'h0014, 1'b0);
    add_token(KIND_OP, 16'h0015, 1'b0);
    add_token(KIND_VALUE, 16'h0016, 1'b1);
    // a ) b: closing without an opening, then the last token is skipped.
    add_token(KIND_VALUE, 16'h8000, 1'b0);
    add_token(KIND_RPAREN, 16'h8001, 1'b0);
    add_token(KIND_VALUE, 16'h8002, 1'b1);
    // Two values in a row.
    add_token(KIND_VALUE, 16'h0100, 1'b0);
    add_token(KIND_VALUE, 16'h0101, 1'b1);
    // A function not followed by '('.
    add_token(KIND_FUNC, 16'h0200, 1'b0);
    add_token(KIND_VALUE, 16'h0201, 1'b1);
    // '(' right after a value.
    add_token(KIND_VALUE, 16'h0300, 1'b0);
    add_token(KIND_LPAREN, 16'h0301, 1'b1);
    // Empty parentheses.
    add_token(KIND_LPAREN, 16'h0400, 1'b0);
    add_token(KIND_RPAREN, 16'h0401, 1'b1);
    // A dangling operator: the stack is empty at the end.
    add_token(KIND_VALUE, 16'h7FFE, 1'b0);
    add_token(KIND_OP, 16'h7FFF, 1'b1);

    // Random part: mostly well-formed expressions with random shape, a quarter
    // of them broken, and now and then one nested to the stack depth.
    counted_tokens = 0;
    expr_index = 0;
    while (counted_tokens < RANDOM_TOKENS) begin
      if (expr_index % 30 == 29) begin
        build_deep(STACK_DEPTH - 1 + (expr_index / 30) % 3);
      end else begin
        build_well_formed($urandom_range(1, 6), $urandom_range(0, 4));
        if ($urandom_range(0, 3) == 0) mutate_expr();
      end
      emit_expr();
      expr_index++;
    end
    phase_len = pending_tokens.size() / 3;

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Wait until every token is transferred and every verdict has been checked.
    while (pending_tokens.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
